// ===== hdl/bcsp_pkg.sv =====
// Package for the bus command string parser: word types, command codes and character constants.
`default_nettype none

package bcsp_pkg;

    // Input word: one character of the command string
    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_string;
    } t_in_word;

    // Output word: one bus command
    typedef struct packed {
        logic [2:0] command;
        logic [7:0] byte_value;
        logic       run_end;
    } t_out_word;

    // Command codes
    localparam logic [2:0] CMD_START = 3'd0;
    localparam logic [2:0] CMD_STOP  = 3'd1;
    localparam logic [2:0] CMD_READ  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_ERROR = 3'd4;

    // Radix of the number being parsed
    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_HEX = 2'd1;
    localparam logic [1:0] RADIX_BIN = 2'd2;

    // Character constants
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_LOW_R    = 8'h72;
    localparam logic [7:0] CH_UP_R     = 8'h52;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_LOW_X    = 8'h78;
    localparam logic [7:0] CH_LOW_H    = 8'h68;
    localparam logic [7:0] CH_LOW_B    = 8'h62;
    localparam logic [7:0] CH_CARET    = 8'h5E;
    localparam logic [7:0] CH_AMP      = 8'h26;
    localparam logic [7:0] CH_ONE      = 8'h31;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_HEX_UP   = 8'h37;
    localparam logic [7:0] CH_HEX_LOW  = 8'h57;
    localparam logic [7:0] CH_AT       = 8'h40;
    localparam logic [7:0] CH_UP_G     = 8'h47;
    localparam logic [7:0] CH_BQUOTE   = 8'h60;
    localparam logic [7:0] CH_LOW_G    = 8'h67;
    localparam logic [7:0] CH_SLASH    = 8'h2F;

endpackage

`default_nettype wire

// ===== hdl/bus_command_string_parser_top.sv =====
// Bus command string parser: character register, parse step and result queue.
// An accepted character waits in the character register until the result queue has
//   room for two words; its words then go into the queue, whose oldest word is shown.
// Throughput: one character per cycle while the queue has room; each gives zero to
//   two words, and the four-entry queue sets the pace, one word per unstalled cycle.
// Reset clears parse state, the character register and the result queue.
`default_nettype none

module bus_command_string_parser_top (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire bcsp_pkg::t_in_word  i_in_word,
    output logic                     o_in_stall,
    output logic                     o_out_valid,
    output bcsp_pkg::t_out_word      o_out_word,
    input  wire logic                i_out_stall
);

    // Character register
    logic               r_in_valid;
    bcsp_pkg::t_in_word r_in_word;

    // Parse state
    logic       r_in_number,   n_in_number;
    logic       r_discarding,  n_discarding;
    logic [1:0] r_digit_index, n_digit_index;
    logic [1:0] r_radix,       n_radix;
    logic [7:0] r_dec_acc,     n_dec_acc;
    logic [7:0] r_hex_acc,     n_hex_acc;
    logic [7:0] r_bin_acc,     n_bin_acc;

    // Result queue
    bcsp_pkg::t_out_word r_queue [4];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_count;

    logic                process;
    logic                pop;
    logic [1:0]          push_cnt;
    bcsp_pkg::t_out_word res0;
    bcsp_pkg::t_out_word res1;

    logic [7:0] ch;
    logic       last;
    logic       numeric;
    logic [7:0] hex_digit;
    logic [7:0] cur_value;
    logic [7:0] new_value;
    logic       own_valid;
    logic [2:0] own_cmd;
    logic [7:0] own_value;

    // Handshake: parse when the queue has room for two words
    assign process     = r_in_valid && (r_count <= 3'd2);
    assign o_in_stall  = r_in_valid && !(r_count <= 3'd2);
    assign pop         = o_out_valid && !i_out_stall;
    assign o_out_valid = (r_count != 3'd0);
    assign o_out_word  = r_queue[r_rd_ptr];

    assign ch   = r_in_word.char_in;
    assign last = r_in_word.end_of_string;

    // Characters that continue a number
    assign numeric = (ch > bcsp_pkg::CH_SLASH  && ch < bcsp_pkg::CH_AT)
                  || (ch > bcsp_pkg::CH_AT     && ch < bcsp_pkg::CH_UP_G)
                  || (ch > bcsp_pkg::CH_BQUOTE && ch < bcsp_pkg::CH_LOW_G)
                  || ch == bcsp_pkg::CH_LOW_X || ch == bcsp_pkg::CH_LOW_H
                  || ch == bcsp_pkg::CH_CARET || ch == bcsp_pkg::CH_AMP
                  || ch == bcsp_pkg::CH_LOW_R;

    // Hex digit offset
    always_comb begin
        if (ch < bcsp_pkg::CH_AT) begin
            hex_digit = ch - bcsp_pkg::CH_ZERO;
        end else if (ch < bcsp_pkg::CH_UP_G) begin
            hex_digit = ch - bcsp_pkg::CH_HEX_UP;
        end else begin
            hex_digit = ch - bcsp_pkg::CH_HEX_LOW;
        end
    end

    // Value of the number so far, by radix
    always_comb begin
        case (r_radix)
            bcsp_pkg::RADIX_HEX: cur_value = r_hex_acc;
            bcsp_pkg::RADIX_BIN: cur_value = r_bin_acc;
            default:             cur_value = r_dec_acc;
        endcase
    end

    // Parse step: next state and up to two result words
    always_comb begin
        n_in_number   = r_in_number;
        n_discarding  = r_discarding;
        n_digit_index = r_digit_index;
        n_radix       = r_radix;
        n_dec_acc     = r_dec_acc;
        n_hex_acc     = r_hex_acc;
        n_bin_acc     = r_bin_acc;
        own_valid     = 1'b0;
        own_cmd       = bcsp_pkg::CMD_START;
        own_value     = 8'd0;
        new_value     = 8'd0;
        push_cnt      = 2'd0;
        res0          = '0;
        res1          = '0;

        if (r_discarding) begin
            // drop everything up to the end of the string
            if (last) begin
                n_discarding = 1'b0;
                n_in_number  = 1'b0;
            end
        end else if (r_in_number && numeric) begin
            // number body
            n_dec_acc = (r_dec_acc << 3) + (r_dec_acc << 1) + (ch - bcsp_pkg::CH_ZERO);
            if (r_digit_index == 2'd1) begin
                if (ch == bcsp_pkg::CH_LOW_X || ch == bcsp_pkg::CH_LOW_H) begin
                    n_radix = bcsp_pkg::RADIX_HEX;
                end else if (ch == bcsp_pkg::CH_LOW_B) begin
                    n_radix = bcsp_pkg::RADIX_BIN;
                end else begin
                    n_radix = bcsp_pkg::RADIX_DEC;
                end
                n_digit_index = 2'd2;
            end else begin
                n_hex_acc = {r_hex_acc[3:0], 4'h0} + hex_digit;
                n_bin_acc = {r_bin_acc[6:0], (ch == bcsp_pkg::CH_ONE)};
            end
            if (last) begin
                // value including this character, by the updated radix
                case (n_radix)
                    bcsp_pkg::RADIX_HEX: new_value = n_hex_acc;
                    bcsp_pkg::RADIX_BIN: new_value = n_bin_acc;
                    default:             new_value = n_dec_acc;
                endcase
                res0        = '{command: bcsp_pkg::CMD_WRITE, byte_value: new_value,
                                run_end: 1'b1};
                push_cnt    = 2'd1;
                n_in_number = 1'b0;
            end
        end else begin
            // character's own meaning, after closing any open number
            n_in_number = 1'b0;
            case (ch)
                bcsp_pkg::CH_LBRACKET, bcsp_pkg::CH_LBRACE: begin
                    own_valid = 1'b1;
                    own_cmd   = bcsp_pkg::CMD_START;
                end
                bcsp_pkg::CH_RBRACKET, bcsp_pkg::CH_RBRACE: begin
                    own_valid = 1'b1;
                    own_cmd   = bcsp_pkg::CMD_STOP;
                end
                bcsp_pkg::CH_LOW_R, bcsp_pkg::CH_UP_R: begin
                    own_valid = 1'b1;
                    own_cmd   = bcsp_pkg::CMD_READ;
                end
                bcsp_pkg::CH_SPACE, bcsp_pkg::CH_COMMA,
                bcsp_pkg::CH_LF, bcsp_pkg::CH_CR: begin
                    own_valid = 1'b0;
                end
                default: begin
                    if (ch[7:4] == 4'h3) begin
                        // first digit of a number
                        n_in_number   = 1'b1;
                        n_digit_index = 2'd1;
                        n_radix       = bcsp_pkg::RADIX_DEC;
                        n_dec_acc     = ch - bcsp_pkg::CH_ZERO;
                        n_hex_acc     = 8'd0;
                        n_bin_acc     = 8'd0;
                        if (last) begin
                            own_valid = 1'b1;
                            own_cmd   = bcsp_pkg::CMD_WRITE;
                            own_value = ch - bcsp_pkg::CH_ZERO;
                        end
                    end else begin
                        own_valid    = 1'b1;
                        own_cmd      = bcsp_pkg::CMD_ERROR;
                        n_discarding = 1'b1;
                    end
                end
            endcase
            if (last) begin
                n_discarding = 1'b0;
                n_in_number  = 1'b0;
            end

            // pack the words: pending write first, then the character's own
            if (r_in_number) begin
                res0 = '{command: bcsp_pkg::CMD_WRITE, byte_value: cur_value,
                         run_end: !own_valid};
                res1 = '{command: own_cmd, byte_value: own_value, run_end: 1'b1};
                push_cnt = own_valid ? 2'd2 : 2'd1;
            end else begin
                res0 = '{command: own_cmd, byte_value: own_value, run_end: 1'b1};
                push_cnt = own_valid ? 2'd1 : 2'd0;
            end
        end
    end

    // Character register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!r_in_valid || process) begin
            r_in_valid <= i_in_valid;
        end
        if (!r_in_valid || process) begin
            r_in_word <= i_in_word;
        end
    end

    // Parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_number   <= 1'b0;
            r_discarding  <= 1'b0;
            r_digit_index <= 2'd0;
            r_radix       <= bcsp_pkg::RADIX_DEC;
            r_dec_acc     <= 8'd0;
            r_hex_acc     <= 8'd0;
            r_bin_acc     <= 8'd0;
        end else if (process) begin
            r_in_number   <= n_in_number;
            r_discarding  <= n_discarding;
            r_digit_index <= n_digit_index;
            r_radix       <= n_radix;
            r_dec_acc     <= n_dec_acc;
            r_hex_acc     <= n_hex_acc;
            r_bin_acc     <= n_bin_acc;
        end
    end

    // Result queue pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            if (process) begin
                r_wr_ptr <= r_wr_ptr + push_cnt;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_count <= r_count + (process ? {1'b0, push_cnt} : 3'd0)
                       - {2'b00, pop};
        end
    end

    // Result queue storage
    always_ff @(posedge i_clk) begin
        if (process && push_cnt != 2'd0) begin
            r_queue[r_wr_ptr] <= res0;
        end
        if (process && push_cnt == 2'd2) begin
            r_queue[r_wr_ptr + 2'd1] <= res1;
        end
    end

    // Checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("result queue count out of range");

    a_stall_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_count > 3'd2))
        else $error("input stalled without a full queue");

    a_pair_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (process && push_cnt == 2'd2) |-> (!res0.run_end && res1.run_end
                                           && res0.command == bcsp_pkg::CMD_WRITE))
        else $error("two-word result misordered");

    a_discard_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (process && r_discarding) |-> (push_cnt == 2'd0))
        else $error("result produced while discarding");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for the bus command string parser: directed table, random command strings.
`timescale 1ns / 1ps

module tb_top;
    import bcsp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 400;
    localparam int DRAIN_CYCLES   = 10;

    // One row of the directed table; typed rows carry at most one plain command
    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
        logic       typed;
        logic       has_word;
        logic [2:0] cmd;
    } t_dir_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    t_in_word   i_in_word = '0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_word  o_out_word;
    logic       i_out_stall = 1'b0;

    // Parser state as the predictor sees it
    logic       num_active = 1'b0;
    logic       skipping = 1'b0;
    logic [1:0] digit_pos = 2'd0;
    logic [1:0] radix_sel = RADIX_DEC;
    logic [7:0] dec_value = 8'h00;
    logic [7:0] hex_value = 8'h00;
    logic [7:0] bin_value = 8'h00;

    t_out_word  step_words[$];
    t_out_word  expected_cmds[$];
    t_in_word   cmd_text[$];
    t_dir_row   dir_rows [25];

    int         in_idle_pct = 0;
    int         out_idle_pct = 0;
    int         error_count = 0;
    int         stalled_cycles = 0;

    bus_command_string_parser_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

    always #2 i_clk = ~i_clk;

    // Characters that keep a number token going
    function automatic logic continues_number(input logic [7:0] c);
        return (c[7:4] == 4'h3) || (c > CH_AT && c < CH_UP_G) ||
               (c > CH_BQUOTE && c < CH_LOW_G) || c == CH_LOW_X ||
               c == CH_LOW_H || c == CH_CARET || c == CH_AMP || c == CH_LOW_R;
    endfunction

    function automatic logic [7:0] hex_weight(input logic [7:0] c);
        if (c < CH_AT) return c - CH_ZERO;
        if (c < CH_UP_G) return c - CH_HEX_UP;
        return c - CH_HEX_LOW;
    endfunction

    function automatic logic [7:0] number_byte();
        if (radix_sel == RADIX_HEX) return hex_value;
        if (radix_sel == RADIX_BIN) return bin_value;
        return dec_value;
    endfunction

    // Append a command; the previous one of this character loses its run end
    function automatic void add_cmd(input logic [2:0] cmd, input logic [7:0] val);
        t_out_word prev;
        if (step_words.size() > 0) begin
            prev = step_words.pop_back();
            prev.run_end = 1'b0;
            step_words.push_back(prev);
        end
        step_words.push_back(t_out_word'{cmd, val, 1'b1});
    endfunction

    // Predict the commands caused by one accepted character
    function automatic void parse_char(input t_in_word w);
        logic [7:0] c;
        logic       eos;
        c = w.char_in;
        eos = w.end_of_string;
        step_words.delete();

        if (skipping) begin
            if (eos) begin
                skipping = 1'b0;
                num_active = 1'b0;
            end
            return;
        end

        // Inside a number: accumulate, or write it out and reparse the character
        if (num_active) begin
            if (continues_number(c)) begin
                dec_value = dec_value * 8'd10 + (c - CH_ZERO);
                if (digit_pos == 2'd1) begin
                    if (c == CH_LOW_X || c == CH_LOW_H) radix_sel = RADIX_HEX;
                    else if (c == CH_LOW_B) radix_sel = RADIX_BIN;
                    else radix_sel = RADIX_DEC;
                    digit_pos = 2'd2;
                end else begin
                    hex_value = {hex_value[3:0], 4'h0} + hex_weight(c);
                    bin_value = {bin_value[6:0], c == CH_ONE};
                end
                if (eos) begin
                    add_cmd(CMD_WRITE, number_byte());
                    num_active = 1'b0;
                end
                return;
            end
            add_cmd(CMD_WRITE, number_byte());
            num_active = 1'b0;
        end

        case (c)
            CH_LBRACKET, CH_LBRACE: add_cmd(CMD_START, 8'h00);
            CH_RBRACKET, CH_RBRACE: add_cmd(CMD_STOP, 8'h00);
            CH_LOW_R, CH_UP_R:      add_cmd(CMD_READ, 8'h00);
            CH_SPACE, CH_COMMA, CH_LF, CH_CR: ;
            default: begin
                if (c[7:4] == 4'h3) begin
                    num_active = 1'b1;
                    digit_pos = 2'd1;
                    radix_sel = RADIX_DEC;
                    dec_value = c - CH_ZERO;
                    hex_value = 8'h00;
                    bin_value = 8'h00;
                    if (eos) begin
                        add_cmd(CMD_WRITE, dec_value);
                        num_active = 1'b0;
                    end
                end else begin
                    add_cmd(CMD_ERROR, 8'h00);
                    skipping = 1'b1;
                end
            end
        endcase

        if (eos) begin
            skipping = 1'b0;
            num_active = 1'b0;
        end
    endfunction

    function automatic logic [7:0] pick_separator();
        case ($urandom_range(0, 3))
            0: return CH_SPACE;
            1: return CH_COMMA;
            2: return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    // Any character that continues a number, including the odd ones
    function automatic logic [7:0] pick_number_char();
        int n;
        n = $urandom_range(0, 32);
        if (n < 16) return CH_ZERO + n[7:0];
        if (n < 22) return 8'h41 + n[7:0] - 8'd16;    // 'A'..'F'
        if (n < 28) return 8'h61 + n[7:0] - 8'd22;    // 'a'..'f'
        case (n)
            28: return CH_LOW_X;
            29: return CH_LOW_H;
            30: return CH_CARET;
            31: return CH_AMP;
            default: return CH_LOW_R;
        endcase
    endfunction

    function automatic void append_char(input logic [7:0] ch);
        cmd_text.push_back(t_in_word'{ch, 1'b0});
    endfunction

    // Build one command string of mostly well-formed tokens, last character flagged
    task automatic build_command_string();
        int         n_tokens;
        int         n_digits;
        int         d;
        t_in_word   last_word;
        cmd_text.delete();
        n_tokens = $urandom_range(1, 6);
        for (int t = 0; t < n_tokens; t++) begin
            case ($urandom_range(0, 11))
                0: append_char($urandom_range(0, 1) ? CH_LBRACKET : CH_LBRACE);
                1: append_char($urandom_range(0, 1) ? CH_RBRACKET : CH_RBRACE);
                2: append_char($urandom_range(0, 1) ? CH_LOW_R : CH_UP_R);
                3: append_char(pick_separator());
                // decimal
                4, 5: begin
                    append_char(CH_ZERO + 8'($urandom_range(0, 9)));
                    n_digits = $urandom_range(0, 3);
                    repeat (n_digits) begin
                        if ($urandom_range(0, 5) == 0) append_char(pick_number_char());
                        else append_char(CH_ZERO + 8'($urandom_range(0, 9)));
                    end
                end
                // hex
                6, 7: begin
                    append_char(CH_ZERO + 8'($urandom_range(0, 15)));
                    append_char($urandom_range(0, 1) ? CH_LOW_X : CH_LOW_H);
                    n_digits = $urandom_range(0, 3);
                    repeat (n_digits) begin
                        d = $urandom_range(0, 15);
                        if ($urandom_range(0, 7) == 0) append_char(pick_number_char());
                        else if (d < 10) append_char(CH_ZERO + 8'(d));
                        else if ($urandom_range(0, 1)) append_char(8'h41 + 8'(d - 10));
                        else append_char(8'h61 + 8'(d - 10));
                    end
                end
                // binary
                8, 9: begin
                    append_char(CH_ZERO + 8'($urandom_range(0, 15)));
                    append_char(CH_LOW_B);
                    n_digits = $urandom_range(0, 9);
                    repeat (n_digits) begin
                        if ($urandom_range(0, 7) == 0) append_char(pick_number_char());
                        else append_char($urandom_range(0, 1) ? CH_ONE : CH_ZERO);
                    end
                end
                10: append_char(8'($urandom_range(0, 255)));
                default: append_char(pick_number_char());
            endcase
            if ($urandom_range(0, 1)) append_char(pick_separator());
        end
        last_word = cmd_text.pop_back();
        last_word.end_of_string = 1'b1;
        cmd_text.push_back(last_word);
    endtask

    // Offer one word, with random idle cycles first; returns at the accepting edge
    task automatic send_word(input t_in_word w);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Receiver stall
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < out_idle_pct);
    end

    // Compare each accepted command word with the oldest expectation
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_cmds.size() == 0) begin
                $display("%0t: unexpected word: expected none, actual cmd=%0d byte=%02h end=%0b",
                         $time, o_out_word.command, o_out_word.byte_value, o_out_word.run_end);
                error_count++;
            end else begin
                want = expected_cmds.pop_front();
                if (o_out_word.command !== want.command ||
                    o_out_word.byte_value !== want.byte_value ||
                    o_out_word.run_end !== want.run_end) begin
                    $display("%0t: mismatch: expected cmd=%0d byte=%02h end=%0b, actual cmd=%0d byte=%02h end=%0b",
                             $time, want.command, want.byte_value, want.run_end,
                             o_out_word.command, o_out_word.byte_value, o_out_word.run_end);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: too long without any word moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            stalled_cycles <= 0;
        end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    initial begin
        int         phase_items;
        t_in_word   w;
        t_dir_row   row;

        // Directed table: every command, separators, each radix, errors and discarding
        dir_rows = '{
            '{CH_LBRACKET, 1'b0, 1'b1, 1'b1, CMD_START},
            '{CH_LOW_R,    1'b0, 1'b1, 1'b1, CMD_READ},
            '{CH_UP_R,     1'b0, 1'b1, 1'b1, CMD_READ},
            '{CH_LBRACE,   1'b0, 1'b1, 1'b1, CMD_START},
            '{CH_RBRACE,   1'b0, 1'b1, 1'b1, CMD_STOP},
            '{CH_RBRACKET, 1'b0, 1'b1, 1'b1, CMD_STOP},
            '{CH_SPACE,    1'b0, 1'b1, 1'b0, CMD_START},
            '{CH_COMMA,    1'b0, 1'b1, 1'b0, CMD_START},
            '{CH_CR,       1'b0, 1'b1, 1'b0, CMD_START},
            '{CH_LF,       1'b0, 1'b1, 1'b0, CMD_START},
            // hex 0xFf, closed by a stop: write then stop from one character
            '{CH_ZERO,     1'b0, 1'b0, 1'b0, CMD_WRITE},
            '{CH_LOW_X,    1'b0, 1'b0, 1'b0, CMD_WRITE},
            '{8'h46,       1'b0, 1'b0, 1'b0, CMD_WRITE},
            '{8'h66,       1'b0, 1'b0, 1'b0, CMD_WRITE},
            '{CH_RBRACKET, 1'b0, 1'b0, 1'b0, CMD_WRITE},
            // binary 0b11 ended by end of string
            '{CH_ZERO,     1'b0, 1'b0, 1'b0, CMD_WRITE},
            '{CH_LOW_B,    1'b0, 1'b0, 1'b0, CMD_WRITE},
            '{CH_ONE,      1'b0, 1'b0, 1'b0, CMD_WRITE},
            '{CH_ONE,      1'b1, 1'b0, 1'b0, CMD_WRITE},
            // single digit that is also the last character
            '{8'h39,       1'b1, 1'b0, 1'b0, CMD_WRITE},
            // bad character, then discard until end of string
            '{8'h2A,       1'b0, 1'b1, 1'b1, CMD_ERROR},
            '{CH_LOW_X,    1'b0, 1'b1, 1'b0, CMD_ERROR},
            '{8'hFF,       1'b1, 1'b1, 1'b0, CMD_ERROR},
            '{8'h00,       1'b1, 1'b1, 1'b1, CMD_ERROR},
            '{8'hFF,       1'b1, 1'b1, 1'b1, CMD_ERROR}
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        in_idle_pct  = 9;
        out_idle_pct = 79;
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            w = t_in_word'{row.ch, row.eos};
            send_word(w);
            parse_char(w);
            if (row.typed) begin
                if (row.has_word) expected_cmds.push_back(t_out_word'{row.cmd, 8'h00, 1'b1});
            end else begin
                foreach (step_words[k]) expected_cmds.push_back(step_words[k]);
            end
        end

        // Random command strings under three idling patterns
        for (int ph = 0; ph < 3; ph++) begin
            in_idle_pct  = (ph == 0) ? 9 : (ph == 1) ? 79 : 0;
            out_idle_pct = (ph == 0) ? 79 : (ph == 1) ? 9 : 0;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                build_command_string();
                foreach (cmd_text[i]) begin
                    if (!skipping) phase_items++;
                    send_word(cmd_text[i]);
                    parse_char(cmd_text[i]);
                    foreach (step_words[k]) expected_cmds.push_back(step_words[k]);
                end
            end
        end
        i_in_valid <= 1'b0;

        // Drain, then give stray words time to show up
        while (expected_cmds.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/bcsp_pkg.sv
hdl/bus_command_string_parser_top.sv
test/tb_top.sv
